// ===== sv/kdrd_pkg.sv =====
// shared types, constants and helpers of the keypoint row decoder
// used by every module of the block; depends on nothing
`default_nettype none

package kdrd_pkg;

    localparam int VALUE_W         = 32;
    localparam int SCALE_W         = 24;
    localparam int OFF_W           = 12;
    localparam int SCALE_FRAC_BITS = 16;
    localparam int PROD_W          = VALUE_W + SCALE_W + 1;
    localparam int NUM_KP          = 4;
    localparam int NUM_COORDS      = 8;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 32;

    localparam logic [4:0] COL_LOGIT       = 5'd8;
    localparam logic [4:0] COL_COLOR_FIRST = 5'd9;
    localparam logic [4:0] COL_COLOR_LAST  = 5'd12;
    localparam logic [4:0] COL_CLASS_FIRST = 5'd13;
    localparam logic [4:0] COL_CLASS_LAST  = 5'd21;

    localparam logic [2:0] NONE_COLOR = 3'd7;
    localparam logic [3:0] NONE_CLASS = 4'd15;

    localparam logic [1:0] ST_OK            = 2'd0;
    localparam logic [1:0] ST_LOW_OBJ       = 2'd1;
    localparam logic [1:0] ST_DEGENERATE    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN_COLOR = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_INV_SCALE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_X  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_Y  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROI_EN    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OBJ_THR   = 3'd4;

    // coordinate slots of each keypoint, keypoint 0 in the low slot
    localparam logic [NUM_KP-1:0][2:0] KP_XCOL = {3'd2, 3'd4, 3'd6, 3'd0};
    localparam logic [NUM_KP-1:0][2:0] KP_YCOL = {3'd3, 3'd5, 3'd7, 3'd1};

    typedef struct packed {
        logic [4:0]                column;
        logic signed [VALUE_W-1:0] tensor_value;
    } kdrd_in_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [1:0]                keypoint_index;
        logic signed [VALUE_W-1:0] keypoint_x;
        logic signed [VALUE_W-1:0] keypoint_y;
        logic signed [VALUE_W-1:0] box_x;
        logic signed [VALUE_W-1:0] box_y;
        logic [VALUE_W-2:0]        box_width;
        logic [VALUE_W-2:0]        box_height;
        logic [1:0]                color;
        logic [3:0]                number;
        logic signed [VALUE_W-1:0] objectness_logit;
        logic                      last;
    } kdrd_out_t;

    typedef struct packed {
        logic [SCALE_W-1:0]        inverse_scale;
        logic [OFF_W-1:0]          offset_x;
        logic [OFF_W-1:0]          offset_y;
        logic                      roi_enable;
        logic signed [VALUE_W-1:0] objectness_threshold;
    } kdrd_cfg_t;

    // item after the multiply stage
    typedef struct packed {
        logic                      valid;
        logic [4:0]                column;
        logic signed [VALUE_W-1:0] value;
        logic signed [PROD_W-1:0]  product;
    } kdrd_prod_t;

    // row snapshot taken after column 21, with the bounding extremes
    typedef struct packed {
        logic [NUM_KP-1:0][VALUE_W-1:0] kx;
        logic [NUM_KP-1:0][VALUE_W-1:0] ky;
        logic signed [VALUE_W-1:0]      min_x;
        logic signed [VALUE_W-1:0]      min_y;
        logic signed [VALUE_W-1:0]      max_x;
        logic signed [VALUE_W-1:0]      max_y;
        logic signed [VALUE_W-1:0]      logit;
        logic [2:0]                     color_index;
        logic [3:0]                     number;
    } kdrd_snap_t;

    // judged row waiting for delivery
    typedef struct packed {
        logic [1:0]                     status;
        logic [NUM_KP-1:0][VALUE_W-1:0] kx;
        logic [NUM_KP-1:0][VALUE_W-1:0] ky;
        logic signed [VALUE_W-1:0]      box_x;
        logic signed [VALUE_W-1:0]      box_y;
        logic [VALUE_W-2:0]             box_width;
        logic [VALUE_W-2:0]             box_height;
        logic [1:0]                     color;
        logic [3:0]                     number;
        logic signed [VALUE_W-1:0]      logit;
    } kdrd_rec_t;

    function automatic logic [3:0] map_number(input logic [3:0] idx);
        logic [3:0] num;
        case (idx) inside
            4'd0:          num = 4'd7;
            [4'd1:4'd6]:   num = idx;
            [4'd7:4'd8]:   num = 4'd8;
            default:       num = 4'd1;
        endcase
        return num;
    endfunction

endpackage

`default_nettype wire

// ===== sv/kdrd_scale.sv =====
// input register and coordinate multiply stage
// depends on kdrd_pkg
`default_nettype none

module kdrd_scale import kdrd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire kdrd_in_t           in_data,
    input  wire logic [SCALE_W-1:0] inverse_scale,
    output kdrd_prod_t              prod
);

    logic     s1_valid_reg;
    kdrd_in_t s1_data_reg;
    logic     s2_valid_reg;
    logic [4:0] s2_column_reg;
    logic signed [VALUE_W-1:0] s2_value_reg;
    logic signed [PROD_W-1:0]  s2_product_reg;
    logic signed [PROD_W-1:0]  product_next;

    assign product_next = s1_data_reg.tensor_value * $signed({1'b0, inverse_scale});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_data_reg    <= in_data;
            s2_column_reg  <= s1_data_reg.column;
            s2_value_reg   <= s1_data_reg.tensor_value;
            s2_product_reg <= product_next;
        end
    end

    assign prod.valid   = s2_valid_reg;
    assign prod.column  = s2_column_reg;
    assign prod.value   = s2_value_reg;
    assign prod.product = s2_product_reg;

endmodule

`default_nettype wire

// ===== sv/kdrd_accum.sv =====
// row state: scaled coordinates, logit, colour and class argmax,
// and the judge stage that takes the row snapshot and box extremes; uses kdrd_pkg
`default_nettype none

module kdrd_accum import kdrd_pkg::*;
#(
    parameter int VALUE_FRAC_BITS = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire kdrd_prod_t prod,
    input  wire kdrd_cfg_t  cfg,
    output logic            snap_valid,
    output kdrd_snap_t      snap
);

    localparam int SUM_W = PROD_W + 1;
    localparam logic signed [VALUE_W-1:0] ONE     = VALUE_W'(1) << VALUE_FRAC_BITS;
    localparam logic signed [VALUE_W-1:0] NEG_ONE = -ONE;
    localparam logic signed [SUM_W-1:0]   ROUND_HALF = SUM_W'(1) << (SCALE_FRAC_BITS - 1);
    localparam logic signed [VALUE_W-1:0] SAT_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] SAT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    logic signed [VALUE_W-1:0] coords_reg [NUM_COORDS];
    logic signed [VALUE_W-1:0] logit_reg, logit_next;
    logic signed [VALUE_W-1:0] color_score_reg, color_score_next;
    logic [2:0]                color_index_reg, color_index_next;
    logic signed [VALUE_W-1:0] class_score_reg, class_score_next;
    logic [3:0]                class_index_reg, class_index_next;
    logic                      judge_reg, judge_next;
    logic                      snap_valid_reg;
    kdrd_snap_t                snap_reg, snap_next;

    logic [OFF_W-1:0]          offset;
    logic [SUM_W-1:0]          offset_term;
    logic signed [SUM_W-1:0]   sum;
    logic                      fits;
    logic signed [VALUE_W-1:0] coord_value;
    logic                      coord_write;
    logic signed [VALUE_W-1:0] color_base, class_base;
    logic [4:0]                color_rel, class_rel;

    // round half up, offset and saturate in one sum, then floor shift
    always_comb
    begin
        offset      = prod.column[0] ? cfg.offset_y : cfg.offset_x;
        offset_term = cfg.roi_enable
                    ? (SUM_W'(offset) << (VALUE_FRAC_BITS + SCALE_FRAC_BITS)) : '0;
        sum  = $signed({prod.product[PROD_W-1], prod.product}) + $signed(offset_term)
             + ROUND_HALF;
        fits = (sum[SUM_W-1:SCALE_FRAC_BITS+VALUE_W-1] == '0)
            || (sum[SUM_W-1:SCALE_FRAC_BITS+VALUE_W-1] == '1);
        if (fits)
            coord_value = sum[SCALE_FRAC_BITS+VALUE_W-1:SCALE_FRAC_BITS];
        else if (sum[SUM_W-1])
            coord_value = SAT_MIN;
        else
            coord_value = SAT_MAX;
    end

    always_comb
    begin
        logit_next       = logit_reg;
        color_score_next = color_score_reg;
        color_index_next = color_index_reg;
        class_score_next = class_score_reg;
        class_index_next = class_index_reg;
        coord_write      = 1'b0;
        color_rel        = prod.column - COL_COLOR_FIRST;
        class_rel        = prod.column - COL_CLASS_FIRST;
        color_base       = (prod.column == COL_COLOR_FIRST) ? NEG_ONE : color_score_reg;
        class_base       = (prod.column == COL_CLASS_FIRST) ? NEG_ONE : class_score_reg;
        if (prod.valid)
        begin
            case (prod.column) inside
                [5'd0:5'd7]:
                    coord_write = 1'b1;
                COL_LOGIT:
                    logit_next = prod.value;
                [COL_COLOR_FIRST:COL_COLOR_LAST]:
                begin
                    if (prod.column == COL_COLOR_FIRST)
                    begin
                        color_score_next = NEG_ONE;
                        color_index_next = NONE_COLOR;
                    end
                    if (prod.value > color_base)
                    begin
                        color_score_next = prod.value;
                        color_index_next = color_rel[2:0];
                    end
                end
                [COL_CLASS_FIRST:COL_CLASS_LAST]:
                begin
                    if (prod.column == COL_CLASS_FIRST)
                    begin
                        class_score_next = NEG_ONE;
                        class_index_next = NONE_CLASS;
                    end
                    if (prod.value > class_base)
                    begin
                        class_score_next = prod.value;
                        class_index_next = class_rel[3:0];
                    end
                end
                default:
                    coord_write = 1'b0;
            endcase
        end
        judge_next = prod.valid && (prod.column == COL_CLASS_LAST);
    end

    // bounding extremes as a two level compare tree over the four keypoints
    always_comb
    begin
        logic signed [VALUE_W-1:0] lo_x_a, lo_x_b, hi_x_a, hi_x_b;
        logic signed [VALUE_W-1:0] lo_y_a, lo_y_b, hi_y_a, hi_y_b;
        for (int k = 0; k < NUM_KP; k++)
        begin
            snap_next.kx[k] = coords_reg[KP_XCOL[k]];
            snap_next.ky[k] = coords_reg[KP_YCOL[k]];
        end
        lo_x_a = (coords_reg[KP_XCOL[1]] < coords_reg[KP_XCOL[0]])
               ? coords_reg[KP_XCOL[1]] : coords_reg[KP_XCOL[0]];
        lo_x_b = (coords_reg[KP_XCOL[3]] < coords_reg[KP_XCOL[2]])
               ? coords_reg[KP_XCOL[3]] : coords_reg[KP_XCOL[2]];
        hi_x_a = (coords_reg[KP_XCOL[1]] > coords_reg[KP_XCOL[0]])
               ? coords_reg[KP_XCOL[1]] : coords_reg[KP_XCOL[0]];
        hi_x_b = (coords_reg[KP_XCOL[3]] > coords_reg[KP_XCOL[2]])
               ? coords_reg[KP_XCOL[3]] : coords_reg[KP_XCOL[2]];
        lo_y_a = (coords_reg[KP_YCOL[1]] < coords_reg[KP_YCOL[0]])
               ? coords_reg[KP_YCOL[1]] : coords_reg[KP_YCOL[0]];
        lo_y_b = (coords_reg[KP_YCOL[3]] < coords_reg[KP_YCOL[2]])
               ? coords_reg[KP_YCOL[3]] : coords_reg[KP_YCOL[2]];
        hi_y_a = (coords_reg[KP_YCOL[1]] > coords_reg[KP_YCOL[0]])
               ? coords_reg[KP_YCOL[1]] : coords_reg[KP_YCOL[0]];
        hi_y_b = (coords_reg[KP_YCOL[3]] > coords_reg[KP_YCOL[2]])
               ? coords_reg[KP_YCOL[3]] : coords_reg[KP_YCOL[2]];
        snap_next.min_x       = (lo_x_b < lo_x_a) ? lo_x_b : lo_x_a;
        snap_next.max_x       = (hi_x_b > hi_x_a) ? hi_x_b : hi_x_a;
        snap_next.min_y       = (lo_y_b < lo_y_a) ? lo_y_b : lo_y_a;
        snap_next.max_y       = (hi_y_b > hi_y_a) ? hi_y_b : hi_y_a;
        snap_next.logit       = logit_reg;
        snap_next.color_index = color_index_reg;
        snap_next.number      = map_number(class_index_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            logit_reg       <= '0;
            color_score_reg <= NEG_ONE;
            color_index_reg <= NONE_COLOR;
            class_score_reg <= NEG_ONE;
            class_index_reg <= NONE_CLASS;
            judge_reg       <= 1'b0;
            snap_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            logit_reg       <= logit_next;
            color_score_reg <= color_score_next;
            color_index_reg <= color_index_next;
            class_score_reg <= class_score_next;
            class_index_reg <= class_index_next;
            judge_reg       <= judge_next;
            snap_valid_reg  <= judge_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && coord_write)
            coords_reg[prod.column[2:0]] <= coord_value;
        if (en && judge_reg)
            snap_reg <= snap_next;
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

`default_nettype wire

// ===== sv/kdrd_emit.sv =====
// row judgement, two-entry record queue and result sequencer
// one or four results per judged row; uses kdrd_pkg
`default_nettype none

module kdrd_emit import kdrd_pkg::*;
#(
    parameter int VALUE_FRAC_BITS = 16
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      snap_valid,
    input  wire kdrd_snap_t                snap,
    input  wire logic signed [VALUE_W-1:0] objectness_threshold,
    output logic                           queue_ready,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output kdrd_out_t                      out_data
);

    localparam logic signed [VALUE_W:0]   ONE_EXT = (VALUE_W+1)'(1) << VALUE_FRAC_BITS;
    localparam logic signed [VALUE_W:0]   WIDE_MAX = (VALUE_W+1)'({(VALUE_W-1){1'b1}});

    kdrd_rec_t  fifo_mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic [1:0] kp_reg;

    kdrd_rec_t               rec;
    kdrd_rec_t               head;
    logic signed [VALUE_W:0] wd, hd;
    logic                    push, pop, take, reject, is_last;

    always_comb
    begin
        wd = $signed({snap.max_x[VALUE_W-1], snap.max_x})
           - $signed({snap.min_x[VALUE_W-1], snap.min_x});
        hd = $signed({snap.max_y[VALUE_W-1], snap.max_y})
           - $signed({snap.min_y[VALUE_W-1], snap.min_y});
        rec.kx         = snap.kx;
        rec.ky         = snap.ky;
        rec.box_x      = snap.min_x;
        rec.box_y      = snap.min_y;
        rec.box_width  = (wd > WIDE_MAX) ? WIDE_MAX[VALUE_W-2:0] : wd[VALUE_W-2:0];
        rec.box_height = (hd > WIDE_MAX) ? WIDE_MAX[VALUE_W-2:0] : hd[VALUE_W-2:0];
        rec.color      = snap.color_index[1:0];
        rec.number     = snap.number;
        rec.logit      = snap.logit;
        if (snap.logit < objectness_threshold)
            rec.status = ST_LOW_OBJ;
        else if ((wd < ONE_EXT) || (hd < ONE_EXT))
            rec.status = ST_DEGENERATE;
        else if (snap.color_index > 3'd3)
            rec.status = ST_UNKNOWN_COLOR;
        else
            rec.status = ST_OK;
    end

    assign queue_ready = (count_reg != 2'd2);
    assign push        = snap_valid && queue_ready;

    assign head      = fifo_mem_reg[rd_ptr_reg];
    assign reject    = (head.status != ST_OK);
    assign is_last   = reject || (kp_reg == 2'd3);
    assign out_valid = (count_reg != 2'd0);
    assign take      = out_valid && out_ready;
    assign pop       = take && is_last;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            kp_reg     <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
                kp_reg     <= 2'd0;
            end
            else if (take)
                kp_reg <= kp_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem_reg[wr_ptr_reg] <= rec;
    end

    // a reject result carries only status, logit and the last flag
    always_comb
    begin
        out_data.status           = head.status;
        out_data.objectness_logit = head.logit;
        out_data.last             = is_last;
        if (reject)
        begin
            out_data.keypoint_index = 2'd0;
            out_data.keypoint_x     = '0;
            out_data.keypoint_y     = '0;
            out_data.box_x          = '0;
            out_data.box_y          = '0;
            out_data.box_width      = '0;
            out_data.box_height     = '0;
            out_data.color          = 2'd0;
            out_data.number         = 4'd0;
        end
        else
        begin
            out_data.keypoint_index = kp_reg;
            out_data.keypoint_x     = head.kx[kp_reg];
            out_data.keypoint_y     = head.ky[kp_reg];
            out_data.box_x          = head.box_x;
            out_data.box_y          = head.box_y;
            out_data.box_width      = head.box_width;
            out_data.box_height     = head.box_height;
            out_data.color          = head.color;
            out_data.number         = head.number;
        end
    end

endmodule

`default_nettype wire

// ===== sv/keypoint_detection_row_decode.sv =====
// Keypoint row decoder. Takes one Q(32-VALUE_FRAC_BITS).VALUE_FRAC_BITS value of a
// 22-column detector row per cycle; columns 0..7 are scaled keypoint coordinates,
// 8 the objectness logit, 9..12 colour scores, 13..21 class scores. Column 21 judges
// the row and yields one reject result or four keypoint results, the last marked.
// Rate: one item per cycle while in_ready is high. Column 21 passes the input
// register, multiply stage, judge stage and snapshot register; the results leave
// a two-entry record queue one per cycle while out_ready is high. Input stalls only
// while that queue is full and a judged row waits to enter it. Configuration writes
// take effect at once and are meant for an idle block. Columns 22..31 are dropped.
// depends on kdrd_pkg, kdrd_scale, kdrd_accum, kdrd_emit
`default_nettype none

module keypoint_detection_row_decode import kdrd_pkg::*;
#(
    parameter int VALUE_FRAC_BITS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire kdrd_in_t               in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output kdrd_out_t                   out_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    kdrd_cfg_t  cfg_reg;
    kdrd_prod_t prod;
    kdrd_snap_t snap;
    logic       snap_valid;
    logic       queue_ready;
    logic       en;

    // scale and accumulate stages hold while a judged row cannot enter the queue
    assign en        = !snap_valid || queue_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inverse_scale        <= SCALE_W'(65536);
            cfg_reg.offset_x             <= '0;
            cfg_reg.offset_y             <= '0;
            cfg_reg.roi_enable           <= 1'b0;
            cfg_reg.objectness_threshold <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_INV_SCALE: cfg_reg.inverse_scale        <= cfg_data[SCALE_W-1:0];
                CFG_OFFSET_X:  cfg_reg.offset_x             <= cfg_data[OFF_W-1:0];
                CFG_OFFSET_Y:  cfg_reg.offset_y             <= cfg_data[OFF_W-1:0];
                CFG_ROI_EN:    cfg_reg.roi_enable           <= cfg_data[0];
                CFG_OBJ_THR:   cfg_reg.objectness_threshold <= $signed(cfg_data[VALUE_W-1:0]);
                default:       cfg_reg.roi_enable           <= cfg_reg.roi_enable;
            endcase
        end
    end

    kdrd_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (in_valid),
        .in_data       (in_data),
        .inverse_scale (cfg_reg.inverse_scale),
        .prod          (prod)
    );

    kdrd_accum #(
        .VALUE_FRAC_BITS (VALUE_FRAC_BITS)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .prod       (prod),
        .cfg        (cfg_reg),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    kdrd_emit #(
        .VALUE_FRAC_BITS (VALUE_FRAC_BITS)
    ) u_emit (
        .clk                  (clk),
        .rst_n                (rst_n),
        .snap_valid           (snap_valid),
        .snap                 (snap),
        .objectness_threshold (cfg_reg.objectness_threshold),
        .queue_ready          (queue_ready),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .out_data             (out_data)
    );

endmodule

`default_nettype wire

// ===== tb/sv/kdrd_row_checker.sv =====
// result checker for keypoint_detection_row_decode: watches the three channels,
// keeps its own copy of the row state and registers, and compares every result
// depends on kdrd_pkg
module kdrd_row_checker
    import kdrd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  kdrd_in_t               in_data,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  kdrd_out_t              out_data,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatch_count,
    output int                     results_due
);

    localparam int FRAC = 16;
    localparam logic signed [31:0] ONE       = 32'sh0001_0000;
    localparam logic signed [31:0] MINUS_ONE = -32'sh0001_0000;
    localparam longint SAT_MAX = 64'sd2147483647;
    localparam longint SAT_MIN = -64'sd2147483648;

    logic [SCALE_W-1:0]  inv_scale;
    logic [OFF_W-1:0]    roi_x;
    logic [OFF_W-1:0]    roi_y;
    logic                roi_on;
    logic signed [31:0]  logit_threshold;

    logic signed [31:0]  kp_coord [NUM_COORDS];
    logic signed [31:0]  row_logit;
    logic signed [31:0]  color_score;
    logic signed [31:0]  class_score;
    logic [2:0]          color_pick;
    logic [3:0]          class_pick;

    kdrd_out_t           expected_results [$];

    function automatic logic signed [31:0] scale_coord(input logic signed [31:0] raw,
                                                       input logic [OFF_W-1:0] off);
        longint acc;
        acc = longint'(raw) * longint'(inv_scale);
        // round half up, then floor
        acc = (acc + 64'sd32768) >>> SCALE_FRAC_BITS;
        if (roi_on)
            acc = acc + (longint'(off) <<< FRAC);
        if (acc > SAT_MAX)
            acc = SAT_MAX;
        else if (acc < SAT_MIN)
            acc = SAT_MIN;
        return acc[31:0];
    endfunction

    function automatic logic [3:0] class_number(input logic [3:0] pick);
        if (pick == 4'd0)
            return 4'd7;
        if (pick <= 4'd6)
            return pick;
        if (pick <= 4'd8)
            return 4'd8;
        return 4'd1;
    endfunction

    function automatic string describe(input kdrd_out_t r);
        return $sformatf({"st=%0d kp=%0d x=%h y=%h bx=%h by=%h bw=%h bh=%h ",
                          "col=%0d num=%0d logit=%h last=%0b"},
                         r.status, r.keypoint_index, r.keypoint_x, r.keypoint_y,
                         r.box_x, r.box_y, r.box_width, r.box_height, r.color,
                         r.number, r.objectness_logit, r.last);
    endfunction

    task automatic take_config(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_INV_SCALE: inv_scale       = data[SCALE_W-1:0];
            CFG_OFFSET_X:  roi_x           = data[OFF_W-1:0];
            CFG_OFFSET_Y:  roi_y           = data[OFF_W-1:0];
            CFG_ROI_EN:    roi_on          = data[0];
            CFG_OBJ_THR:   logit_threshold = data;
            default:       ;
        endcase
    endtask

    task automatic decode_column(input kdrd_in_t item);
        logic signed [31:0] v;
        logic signed [31:0] lo_x;
        logic signed [31:0] lo_y;
        logic signed [31:0] hi_x;
        logic signed [31:0] hi_y;
        logic signed [31:0] px;
        logic signed [31:0] py;
        longint             span_x;
        longint             span_y;
        logic [1:0]         verdict;
        kdrd_out_t          res;
        v = item.tensor_value;
        if (item.column < 5'd8)
        begin
            kp_coord[item.column[2:0]] = scale_coord(v, item.column[0] ? roi_y : roi_x);
        end
        else if (item.column == COL_LOGIT)
        begin
            row_logit = v;
        end
        else if (item.column <= COL_COLOR_LAST)
        begin
            if (item.column == COL_COLOR_FIRST)
            begin
                color_score = MINUS_ONE;
                color_pick  = NONE_COLOR;
            end
            // strictly greater, so the first of equal scores stays
            if (v > color_score)
            begin
                color_score = v;
                color_pick  = 3'(item.column - COL_COLOR_FIRST);
            end
        end
        else if (item.column <= COL_CLASS_LAST)
        begin
            if (item.column == COL_CLASS_FIRST)
            begin
                class_score = MINUS_ONE;
                class_pick  = NONE_CLASS;
            end
            if (v > class_score)
            begin
                class_score = v;
                class_pick  = 4'(item.column - COL_CLASS_FIRST);
            end
            if (item.column == COL_CLASS_LAST)
            begin
                lo_x = kp_coord[KP_XCOL[0]];
                lo_y = kp_coord[KP_YCOL[0]];
                hi_x = lo_x;
                hi_y = lo_y;
                for (int k = 1; k < NUM_KP; k++)
                begin
                    px = kp_coord[KP_XCOL[k]];
                    py = kp_coord[KP_YCOL[k]];
                    if (px < lo_x) lo_x = px;
                    if (py < lo_y) lo_y = py;
                    if (px > hi_x) hi_x = px;
                    if (py > hi_y) hi_y = py;
                end
                span_x = longint'(hi_x) - longint'(lo_x);
                span_y = longint'(hi_y) - longint'(lo_y);
                if (span_x > SAT_MAX) span_x = SAT_MAX;
                if (span_y > SAT_MAX) span_y = SAT_MAX;

                if (row_logit < logit_threshold)
                    verdict = ST_LOW_OBJ;
                else if (span_x < longint'(ONE) || span_y < longint'(ONE))
                    verdict = ST_DEGENERATE;
                else if (color_pick > 3'd3)
                    verdict = ST_UNKNOWN_COLOR;
                else
                    verdict = ST_OK;

                if (verdict != ST_OK)
                begin
                    res = '0;
                    res.status           = verdict;
                    res.objectness_logit = row_logit;
                    res.last             = 1'b1;
                    expected_results.push_back(res);
                end
                else
                begin
                    for (int k = 0; k < NUM_KP; k++)
                    begin
                        res.status           = ST_OK;
                        res.keypoint_index   = 2'(k);
                        res.keypoint_x       = kp_coord[KP_XCOL[k]];
                        res.keypoint_y       = kp_coord[KP_YCOL[k]];
                        res.box_x            = lo_x;
                        res.box_y            = lo_y;
                        res.box_width        = span_x[30:0];
                        res.box_height       = span_y[30:0];
                        res.color            = color_pick[1:0];
                        res.number           = class_number(class_pick);
                        res.objectness_logit = row_logit;
                        res.last             = (k == NUM_KP - 1);
                        expected_results.push_back(res);
                    end
                end
            end
        end
    endtask

    task automatic match_result(input kdrd_out_t got);
        kdrd_out_t want;
        if (expected_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: result with none expected: %s", $time, describe(got));
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status || got.keypoint_index !== want.keypoint_index ||
            got.keypoint_x !== want.keypoint_x || got.keypoint_y !== want.keypoint_y ||
            got.box_x !== want.box_x || got.box_y !== want.box_y ||
            got.box_width !== want.box_width || got.box_height !== want.box_height ||
            got.color !== want.color || got.number !== want.number ||
            got.objectness_logit !== want.objectness_logit || got.last !== want.last)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                         $time, describe(want), describe(got));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_scale       = 24'h01_0000;
            roi_x           = '0;
            roi_y           = '0;
            roi_on          = 1'b0;
            logit_threshold = '0;
            for (int i = 0; i < NUM_COORDS; i++)
                kp_coord[i] = '0;
            row_logit      = '0;
            color_score    = MINUS_ONE;
            color_pick     = NONE_COLOR;
            class_score    = MINUS_ONE;
            class_pick     = NONE_CLASS;
            mismatch_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                take_config(cfg_index, cfg_data);
            if (in_valid && in_ready)
                decode_column(in_data);
            if (out_valid && out_ready)
                match_result(out_data);
        end
        results_due = expected_results.size();
    end

endmodule

// ===== tb/sv/tb_keypoint_detection_row_decode.sv =====
// top of the keypoint_detection_row_decode testbench: clock, reset, register
// writes, row stimulus with random gaps and back-pressure, watchdog and verdict
// depends on kdrd_pkg, keypoint_detection_row_decode and kdrd_row_checker
module tb_keypoint_detection_row_decode;

    import kdrd_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 10;
    localparam int STALL_LIMIT   = 5000;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    kdrd_in_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    kdrd_out_t              out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int                     mismatch_count;
    int                     results_due;
    int                     send_idle_pct;
    int                     recv_idle_pct;
    bit                     hold_req;
    logic [31:0]            cur_threshold;

    keypoint_detection_row_decode uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    kdrd_row_checker row_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] coord_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return 32'h7FFF_FFFF;
        if (pick < 10)
            return 32'h8000_0000;
        if (pick < 25)
            return $urandom();
        // within +-512.0 most of the time
        return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
    endfunction

    function automatic logic [31:0] score_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return $urandom();
        if (pick < 20)
            return 32'hFFFF_0000 - 32'($urandom_range(0, 32'h0010_0000));
        // half steps from -1.0 to 2.0, so ties and the -1.0 floor come up often
        return 32'($urandom_range(0, 6)) * 32'h0000_8000 - 32'h0001_0000;
    endfunction

    function automatic logic [31:0] logit_value();
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return cur_threshold + 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
    endfunction

    function automatic logic [31:0] column_value(input logic [4:0] col);
        if (col < COL_LOGIT)
            return coord_value();
        if (col == COL_LOGIT)
            return logit_value();
        if (col <= COL_CLASS_LAST)
            return score_value();
        return $urandom();
    endfunction

    // entered anywhere after a rising edge, returns right after the item is taken
    task automatic send_item(input logic [4:0] col, input logic [31:0] val);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {col, val};
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
    endtask

    // upper data bits beyond each register are junk on purpose
    task automatic load_config(input logic [23:0] scale, input logic [11:0] ox,
                               input logic [11:0] oy, input bit roi,
                               input logic [31:0] thr);
        write_reg(CFG_INV_SCALE, {8'($urandom), scale});
        write_reg(CFG_OFFSET_X, {20'($urandom), ox});
        write_reg(CFG_OFFSET_Y, {20'($urandom), oy});
        write_reg(CFG_ROI_EN, {31'($urandom), roi});
        write_reg(CFG_OBJ_THR, thr);
        cur_threshold = thr;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        // ignored columns may still be in the pipe
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_full_row();
        logic [31:0] base;
        bit          narrow;
        narrow = ($urandom_range(0, 99) < 20);
        base   = coord_value();
        for (int c = 0; c <= COL_CLASS_LAST; c++)
        begin
            // narrow rows cluster all coordinates to provoke a thin box
            if (narrow && c < COL_LOGIT)
                send_item(5'(c), base + 32'($urandom_range(0, 32'h0000_C000)));
            else
                send_item(5'(c), column_value(5'(c)));
        end
    endtask

    // partial row over the state of earlier rows: any order, stray columns
    task automatic send_short_row(input bit always_judge);
        int         n;
        int         pick;
        logic [4:0] col;
        n = $urandom_range(1, 8);
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                col = 5'($urandom_range(0, 20));
            else if (pick < 80)
                col = 5'($urandom_range(22, 31));
            else
                col = COL_LOGIT;
            send_item(col, column_value(col));
        end
        if (always_judge || $urandom_range(0, 99) < 80)
            send_item(COL_CLASS_LAST, column_value(COL_CLASS_LAST));
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL keypoint_detection_row_decode");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        hold_req      = 1'b0;
        send_idle_pct = 36;
        recv_idle_pct = 71;
        cur_threshold = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        load_config(24'h01_0000, 12'd0, 12'd0, 1'b0, 32'd0);

        // full row at unit scale: extreme coordinates saturate the box,
        // logit equal to the threshold passes, tied colours, no class
        send_item(5'd0, 32'h7FFF_FFFF);
        send_item(5'd1, 32'h8000_0000);
        send_item(5'd2, 32'h8000_0000);
        send_item(5'd3, 32'h7FFF_FFFF);
        send_item(5'd4, 32'h0001_0000);
        send_item(5'd5, 32'hFFFF_0000);
        send_item(5'd6, 32'h0000_0000);
        send_item(5'd7, 32'h0002_0000);
        send_item(COL_LOGIT, 32'h0000_0000);
        for (int c = COL_COLOR_FIRST; c <= COL_COLOR_LAST; c++)
            send_item(5'(c), 32'h0000_8000);
        for (int c = COL_CLASS_FIRST; c <= COL_CLASS_LAST; c++)
            send_item(5'(c), 32'hFFFF_0000);
        send_item(5'd22, 32'h0000_0000);
        send_item(5'd31, 32'hFFFF_FFFF);
        // low objectness
        send_item(COL_LOGIT, 32'h8000_0000);
        send_item(COL_CLASS_LAST, 32'h0003_0000);
        // no colour above -1.0
        send_item(COL_LOGIT, 32'h7FFF_FFFF);
        send_item(COL_COLOR_FIRST, 32'hFFFF_0000);
        send_item(COL_CLASS_LAST, 32'h0000_0000);
        // box narrower than one pixel
        send_item(5'd0, 32'h0000_8000);
        send_item(5'd2, 32'h0000_0000);
        send_item(5'd4, 32'h0000_0000);
        send_item(5'd6, 32'h0000_0000);
        send_item(COL_CLASS_LAST, 32'h0000_0000);
        // width of exactly 1.0, last colour wins, class 0 ties with class 8
        send_item(5'd0, 32'h0001_0000);
        send_item(5'd9, 32'hFFFF_0000);
        send_item(5'd10, 32'hFFFF_0000);
        send_item(5'd11, 32'hFFFF_0000);
        send_item(5'd12, 32'hFFFF_0001);
        send_item(COL_CLASS_FIRST, 32'h0005_0000);
        send_item(COL_CLASS_LAST, 32'h0005_0000);

        for (int phase = 0; phase < 6; phase++)
        begin
            wait_idle();
            case (phase)
                0: load_config(24'h01_0000, 12'd0, 12'd0, 1'b0, 32'd0);
                1: load_config(24'hFF_FFFF, 12'hFFF, 12'hFFF, 1'b1, 32'h8000_0000);
                2: load_config(24'h00_0000, 12'($urandom), 12'($urandom), 1'b1,
                               32'h7FFF_FFFF);
                3: load_config(24'($urandom_range(16384, 196608)), 12'($urandom),
                               12'($urandom), 1'b0,
                               32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000);
                4: load_config(24'($urandom_range(16384, 196608)), 12'($urandom),
                               12'($urandom), 1'b1,
                               32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000);
                default: load_config(24'($urandom_range(60000, 70000)),
                                     12'($urandom_range(0, 15)), 12'($urandom_range(0, 15)),
                                     1'($urandom), 32'd0);
            endcase
            if (phase < 2)
            begin
                send_idle_pct = 36;
                recv_idle_pct = 71;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 71;
                recv_idle_pct = 36;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // last phase: output held off while rows keep coming, so the input backs up
            if (phase == 5)
                hold_req = 1'b1;
            send_full_row();
            repeat (3) send_short_row(phase == 5);
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("PASS keypoint_detection_row_decode");
        else
            $display("FAIL keypoint_detection_row_decode");
        $finish;
    end

endmodule
